// ===== hdl/ordered_list_engine_assert.svh =====
// assertion macros for the ordered list engine
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ole_pkg.sv =====
// shared constants, codes and control types of the ordered list engine
`default_nettype none

package ole_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_VALUE = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ_ALL  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd4;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_COUNT,
    PTR_LAST,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_PTR,
    RD_PTR_M1,
    RD_PTR_P1
  } rd_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_RDATA,
    WR_VALUE
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic                cap;
    ptr_op_t             ptr_op;
    rd_op_t              rd_op;
    wr_op_t              wr_op;
    cnt_op_t             cnt_op;
    logic                out_load;
    logic                out_read;
    logic [STATUS_W-1:0] out_status;
  } ole_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             empty;
    logic             full;
    logic             bad_pos;
    logic             ptr_gt_idx;
    logic             more_after;
    logic             ptr_last;
    logic             match;
    logic             out_free;
  } ole_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ole_ifs.sv =====
// request and result channel interfaces of the ordered list engine
`default_nettype none

interface ole_in_if;
  logic                                valid;
  logic                                ready;
  logic        [ole_pkg::REQ_W-1:0]    req_type;
  logic signed [ole_pkg::VALUE_W-1:0]  value;
  logic        [ole_pkg::POS_W-1:0]    position;

  modport source (output valid, req_type, value, position, input ready);
  modport sink (input valid, req_type, value, position, output ready);
endinterface

interface ole_out_if;
  logic                                valid;
  logic                                ready;
  logic        [ole_pkg::STATUS_W-1:0] status;
  logic signed [ole_pkg::VALUE_W-1:0]  read_value;
  logic                                last;
  logic        [ole_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, status, read_value, last, entry_count, input ready);
  modport sink (input valid, status, read_value, last, entry_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/ordered_list_engine.sv =====
// Top level of the ordered list engine: a bounded list of signed 32-bit values.
// in_chan carries one request word (req_type, value, position); out_chan gives
// result words (status, read_value, last, entry_count), with last high on the
// final word of each request. Both channels move a word when valid and ready
// are high at a rising clk edge.
// A request is taken only while the controller is idle. It is checked in the
// check state; an insert then shifts the entries behind its target one place
// back through the entry memory, each moved entry read and then written, and a
// delete shifts the entries behind it forward the same way. Delete by value
// first reads and compares the entries from the front until one matches. Read
// all reads each entry and gives it as a result word, waiting while out_chan is
// not free. Once a result is loaded the engine is idle again, so the next
// request can be taken while that word may still wait at out_chan.
// If out_chan stalls, the engine still takes one more request and works it
// through, then waits in front of its first result word with in_chan not ready
// until the pending word leaves. rst_n (synchronous, active low) empties the
// list and drops any pending word at once; the entry memory is not cleared.
`default_nettype none

module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ole_in_if.sink     in_chan,
  ole_out_if.source  out_chan
);

  ole_pkg::ole_cmd_t  cmd;
  ole_pkg::ole_stat_t stat;

  ole_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ole_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_chan.req_type),
    .in_value        (in_chan.value),
    .in_position     (in_chan.position),
    .out_ready       (out_chan.ready),
    .out_valid       (out_chan.valid),
    .out_status      (out_chan.status),
    .out_read_value  (out_chan.read_value),
    .out_last        (out_chan.last),
    .out_entry_count (out_chan.entry_count)
  );

endmodule

`default_nettype wire

// ===== hdl/ole_datapath.sv =====
// entry memory, count, walk pointer, request capture and result register
`default_nettype none
`include "ordered_list_engine_assert.svh"

module ole_datapath #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire ole_pkg::ole_cmd_t                   cmd,
  output ole_pkg::ole_stat_t                       stat,
  input  wire logic        [ole_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic signed [ole_pkg::VALUE_W-1:0]  in_value,
  input  wire logic        [ole_pkg::POS_W-1:0]    in_position,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic             [ole_pkg::STATUS_W-1:0] out_status,
  output logic signed      [ole_pkg::VALUE_W-1:0]  out_read_value,
  output logic                                     out_last,
  output logic             [ole_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ole_pkg::POS_W + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic        [ole_pkg::REQ_W-1:0]    req_r;
  logic signed [ole_pkg::VALUE_W-1:0]  value_r;
  logic        [ole_pkg::POS_W-1:0]    pos_r;

  logic        [CW-1:0]                count_r, count_nxt;
  logic        [CW-1:0]                ptr_r, ptr_nxt;
  logic        [CW-1:0]                ptr_p1;
  logic        [CW-1:0]                ins_idx;
  logic        [PW-1:0]                pos_ext, lim_ext;

  logic signed [ole_pkg::VALUE_W-1:0]  mem [CAPACITY];
  logic signed [ole_pkg::VALUE_W-1:0]  rdata_r;
  logic signed [ole_pkg::VALUE_W-1:0]  wr_data;
  logic        [AW-1:0]                rd_addr;
  logic                                rd_en, wr_en;

  logic                                out_valid_r;
  logic        [ole_pkg::STATUS_W-1:0] out_status_r;
  logic signed [ole_pkg::VALUE_W-1:0]  out_value_r;
  logic                                out_last_r;
  logic        [ole_pkg::COUNT_W-1:0]  out_count_r;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r   <= in_req_type;
      value_r <= in_value;
      pos_r   <= in_position;
    end
  end

  assign ptr_p1  = CW'(ptr_r + CW'(1));
  assign pos_ext = PW'(pos_r);
  assign lim_ext = PW'(count_r) + PW'(1);

  always_comb begin
    priority if (req_r == ole_pkg::REQ_INS_FRONT) begin
      ins_idx = '0;
    end else if (req_r == ole_pkg::REQ_INS_BACK) begin
      ins_idx = count_r;
    end else begin
      ins_idx = CW'(pos_r - ole_pkg::POS_W'(1));
    end
  end

  always_comb begin
    stat.req        = req_r;
    stat.empty      = (count_r == '0);
    stat.full       = (count_r == CAP_C);
    stat.bad_pos    = (pos_r == '0) || (pos_ext > lim_ext);
    stat.ptr_gt_idx = (ptr_r > ins_idx);
    stat.more_after = (ptr_p1 < count_r);
    stat.ptr_last   = (ptr_p1 == count_r);
    stat.match      = (rdata_r == value_r);
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    unique case (cmd.ptr_op)
      ole_pkg::PTR_HOLD:  ptr_nxt = ptr_r;
      ole_pkg::PTR_ZERO:  ptr_nxt = '0;
      ole_pkg::PTR_COUNT: ptr_nxt = count_r;
      ole_pkg::PTR_LAST:  ptr_nxt = CW'(count_r - CW'(1));
      ole_pkg::PTR_INC:   ptr_nxt = ptr_p1;
      ole_pkg::PTR_DEC:   ptr_nxt = CW'(ptr_r - CW'(1));
      default:            ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      ole_pkg::CNT_HOLD: count_nxt = count_r;
      ole_pkg::CNT_INC:  count_nxt = CW'(count_r + CW'(1));
      ole_pkg::CNT_DEC:  count_nxt = CW'(count_r - CW'(1));
      default:           count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // entry memory, one write and one registered read per cycle
  always_comb begin
    rd_en = (cmd.rd_op != ole_pkg::RD_NONE);
    unique case (cmd.rd_op)
      ole_pkg::RD_PTR:    rd_addr = ptr_r[AW-1:0];
      ole_pkg::RD_PTR_M1: rd_addr = AW'(ptr_r - CW'(1));
      ole_pkg::RD_PTR_P1: rd_addr = ptr_p1[AW-1:0];
      default:            rd_addr = ptr_r[AW-1:0];
    endcase
    wr_en   = (cmd.wr_op != ole_pkg::WR_NONE);
    wr_data = (cmd.wr_op == ole_pkg::WR_VALUE) ? value_r : rdata_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_value_r  <= cmd.out_read ? rdata_r : '0;
      out_last_r   <= cmd.out_read ? stat.ptr_last : 1'b1;
      out_count_r  <= ole_pkg::COUNT_W'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_value_r;
  assign out_last        = out_last_r;
  assign out_entry_count = out_count_r;

  `OLE_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CAP_C, "entry count above capacity")
  `OLE_ASSERT_IMPL(a_no_grow_full, cmd.cnt_op == ole_pkg::CNT_INC, count_r < CAP_C, "insert into full list")
  `OLE_ASSERT_IMPL(a_no_shrink_empty, cmd.cnt_op == ole_pkg::CNT_DEC, count_r != '0, "delete from empty list")
  `OLE_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid_r || out_ready, "result word overwritten")
  `OLE_ASSERT_NEXT(a_read_in_range, cmd.rd_op == ole_pkg::RD_PTR, stat.ptr_last || stat.more_after, "read beyond list end")

endmodule

`default_nettype wire

// ===== hdl/ole_ctrl.sv =====
// controller state machine sequencing checks, shifts, search and read out
`default_nettype none

module ole_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ole_pkg::ole_stat_t stat,
  output ole_pkg::ole_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RD_RD,
    S_RD_OUT,
    S_EMIT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [ole_pkg::STATUS_W-1:0]   st_r, st_nxt;

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    cmd.cap        = 1'b0;
    cmd.ptr_op     = ole_pkg::PTR_HOLD;
    cmd.rd_op      = ole_pkg::RD_NONE;
    cmd.wr_op      = ole_pkg::WR_NONE;
    cmd.cnt_op     = ole_pkg::CNT_HOLD;
    cmd.out_load   = 1'b0;
    cmd.out_read   = 1'b0;
    cmd.out_status = st_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        st_nxt    = ole_pkg::ST_OK;
        state_nxt = S_EMIT;
        unique case (stat.req)
          ole_pkg::REQ_INS_FRONT, ole_pkg::REQ_INS_BACK: begin
            if (stat.full) begin
              st_nxt = ole_pkg::ST_FULL;
            end else begin
              cmd.ptr_op = ole_pkg::PTR_COUNT;
              state_nxt  = S_INS_RD;
            end
          end
          ole_pkg::REQ_INS_POS: begin
            priority if (stat.bad_pos) begin
              st_nxt = ole_pkg::ST_BADPOS;
            end else if (stat.full) begin
              st_nxt = ole_pkg::ST_FULL;
            end else begin
              cmd.ptr_op = ole_pkg::PTR_COUNT;
              state_nxt  = S_INS_RD;
            end
          end
          ole_pkg::REQ_DEL_FRONT, ole_pkg::REQ_DEL_BACK: begin
            if (stat.empty) begin
              st_nxt = ole_pkg::ST_EMPTY;
            end else begin
              cmd.ptr_op = (stat.req == ole_pkg::REQ_DEL_FRONT) ?
                           ole_pkg::PTR_ZERO : ole_pkg::PTR_LAST;
              state_nxt  = S_DEL_RD;
            end
          end
          ole_pkg::REQ_DEL_VALUE: begin
            if (stat.empty) begin
              st_nxt = ole_pkg::ST_EMPTY;
            end else begin
              cmd.ptr_op = ole_pkg::PTR_ZERO;
              state_nxt  = S_SRCH_RD;
            end
          end
          ole_pkg::REQ_READ_ALL: begin
            if (stat.empty) begin
              st_nxt = ole_pkg::ST_EMPTY;
            end else begin
              cmd.ptr_op = ole_pkg::PTR_ZERO;
              state_nxt  = S_RD_RD;
            end
          end
          default: begin
            st_nxt = ole_pkg::ST_OK;
          end
        endcase
      end
      S_INS_RD: begin
        if (stat.ptr_gt_idx) begin
          cmd.rd_op = ole_pkg::RD_PTR_M1;
          state_nxt = S_INS_WR;
        end else begin
          cmd.wr_op  = ole_pkg::WR_VALUE;
          cmd.cnt_op = ole_pkg::CNT_INC;
          state_nxt  = S_EMIT;
        end
      end
      S_INS_WR: begin
        cmd.wr_op  = ole_pkg::WR_RDATA;
        cmd.ptr_op = ole_pkg::PTR_DEC;
        state_nxt  = S_INS_RD;
      end
      S_DEL_RD: begin
        if (stat.more_after) begin
          cmd.rd_op = ole_pkg::RD_PTR_P1;
          state_nxt = S_DEL_WR;
        end else begin
          cmd.cnt_op = ole_pkg::CNT_DEC;
          st_nxt     = ole_pkg::ST_OK;
          state_nxt  = S_EMIT;
        end
      end
      S_DEL_WR: begin
        cmd.wr_op  = ole_pkg::WR_RDATA;
        cmd.ptr_op = ole_pkg::PTR_INC;
        state_nxt  = S_DEL_RD;
      end
      S_SRCH_RD: begin
        cmd.rd_op = ole_pkg::RD_PTR;
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        priority if (stat.match) begin
          state_nxt = S_DEL_RD;
        end else if (stat.ptr_last) begin
          st_nxt    = ole_pkg::ST_NOTFOUND;
          state_nxt = S_EMIT;
        end else begin
          cmd.ptr_op = ole_pkg::PTR_INC;
          state_nxt  = S_SRCH_RD;
        end
      end
      S_RD_RD: begin
        cmd.rd_op = ole_pkg::RD_PTR;
        state_nxt = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_read   = 1'b1;
          cmd.out_status = ole_pkg::ST_OK;
          if (stat.ptr_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ptr_op = ole_pkg::PTR_INC;
            state_nxt  = S_RD_RD;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ole_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

// ===== tb/sv/tb_ordered_list_engine.sv =====
// self-checking testbench for the ordered list engine: driver, monitor, list predictor
module tb_ordered_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ole_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 4 * CAP;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct {
    logic        [REQ_W-1:0]   req_type;
    logic signed [VALUE_W-1:0] value;
    logic        [POS_W-1:0]   position;
  } request_t;

  typedef struct {
    logic        [STATUS_W-1:0] status;
    logic signed [VALUE_W-1:0]  read_value;
    logic                       last;
    logic        [COUNT_W-1:0]  entry_count;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ole_in_if  req_chan ();
  ole_out_if res_chan ();

  ordered_list_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan),
    .out_chan (res_chan)
  );

  request_t                  request_backlog[$];
  request_t                  offered;
  bit                        offering = 1'b0;
  logic signed [VALUE_W-1:0] list_shadow[$];
  result_word_t              words_owed[$];
  logic signed [VALUE_W-1:0] recent_values[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void owe_word(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] v,
                                   logic fin);
    result_word_t w;
    w.status      = st;
    w.read_value  = v;
    w.last        = fin;
    w.entry_count = COUNT_W'(list_shadow.size());
    words_owed.push_back(w);
  endfunction

  function automatic void list_apply(request_t r);
    logic [STATUS_W-1:0] st;
    int n;
    int hit;
    int i;
    st  = ST_OK;
    n   = list_shadow.size();
    hit = -1;
    case (r.req_type)
      REQ_INS_FRONT, REQ_INS_BACK: begin
        if (n >= CAP) st = ST_FULL;
        else if (r.req_type == REQ_INS_FRONT) list_shadow.push_front(r.value);
        else list_shadow.push_back(r.value);
      end
      REQ_INS_POS: begin
        if (r.position == 0 || r.position > n + 1) st = ST_BADPOS;
        else if (n >= CAP) st = ST_FULL;
        else list_shadow.insert(r.position - 1, r.value);
      end
      REQ_DEL_FRONT, REQ_DEL_BACK: begin
        if (n == 0) st = ST_EMPTY;
        else if (r.req_type == REQ_DEL_FRONT) void'(list_shadow.pop_front());
        else void'(list_shadow.pop_back());
      end
      REQ_DEL_VALUE: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else begin
          for (i = n - 1; i >= 0; i--)
            if (list_shadow[i] == r.value) hit = i;
          if (hit < 0) st = ST_NOTFOUND;
          else list_shadow.delete(hit);
        end
      end
      REQ_READ_ALL: begin
        if (n == 0) begin
          st = ST_EMPTY;
        end else begin
          for (i = 0; i < n; i++)
            owe_word(ST_OK, list_shadow[i], i == n - 1);
          return;
        end
      end
      default: ;
    endcase
    owe_word(st, '0, 1'b1);
  endfunction

  function automatic void enqueue_request(logic [REQ_W-1:0] rq, logic signed [VALUE_W-1:0] v,
                                          logic [POS_W-1:0] p);
    request_t r;
    r.req_type = rq;
    r.value    = v;
    r.position = p;
    request_backlog.push_back(r);
  endfunction

  function automatic request_t random_request(bit growing);
    request_t r;
    int roll;
    int pick;
    roll = $urandom_range(99);
    if ($urandom_range(3) == 0) r.value = $signed($urandom_range(4)) - 32'sd2;
    else r.value = $urandom;
    pick = $urandom_range(9);
    if (pick == 0) r.position = '0;
    else if (pick == 1) r.position = POS_W'($urandom_range(127, CAP + 2));
    else r.position = POS_W'($urandom_range(CAP + 1, 1));
    if (roll < (growing ? 60 : 20)) begin
      case ($urandom_range(2))
        0: r.req_type = REQ_INS_FRONT;
        1: r.req_type = REQ_INS_BACK;
        default: r.req_type = REQ_INS_POS;
      endcase
      recent_values.push_back(r.value);
      if (recent_values.size() > CAP) void'(recent_values.pop_front());
    end else if (roll < (growing ? 82 : 80)) begin
      case ($urandom_range(2))
        0: r.req_type = REQ_DEL_FRONT;
        1: r.req_type = REQ_DEL_BACK;
        default: begin
          r.req_type = REQ_DEL_VALUE;
          if (recent_values.size() != 0 && $urandom_range(4) != 0)
            r.value = recent_values[$urandom_range(recent_values.size() - 1)];
        end
      endcase
    end else if (roll < 97) begin
      r.req_type = REQ_READ_ALL;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic settle();
    while (request_backlog.size() != 0 || offering || words_owed.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  always @(negedge clk) begin : driver
    if (!rst_n) begin
      req_chan.valid <= 1'b0;
    end else if (!offering) begin
      if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        offered  = request_backlog.pop_front();
        offering = 1'b1;
        req_chan.valid    <= 1'b1;
        req_chan.req_type <= offered.req_type;
        req_chan.value    <= offered.value;
        req_chan.position <= offered.position;
      end else begin
        req_chan.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      res_chan.ready <= 1'b0;
      hold_left--;
    end else begin
      res_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    result_word_t got;
    result_word_t want;
    if (rst_n && req_chan.valid && req_chan.ready) begin
      list_apply(offered);
      offering = 1'b0;
    end
    if (rst_n && res_chan.valid && res_chan.ready) begin
      got.status      = res_chan.status;
      got.read_value  = res_chan.read_value;
      got.last        = res_chan.last;
      got.entry_count = res_chan.entry_count;
      if (words_owed.size() == 0) begin
        $error("result word with nothing owed: status %0d read_value %0d last %0d count %0d",
               got.status, got.read_value, got.last, got.entry_count);
        mismatches++;
      end else begin
        want = words_owed.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          mismatches++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_ordered_list_engine failed");
      $finish;
    end
  end

  initial begin : stimulus
    int idle_plan[4];
    int stall_plan[4];
    int p;
    int b;
    int k;
    idle_plan  = '{0, 61, 0, 20};
    stall_plan = '{0, 0, 61, 20};
    req_chan.valid    = 1'b0;
    req_chan.req_type = '0;
    req_chan.value    = '0;
    req_chan.position = '0;
    res_chan.ready    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // empty list, position checks, single entry removal, extremes, ordering
    enqueue_request(REQ_READ_ALL, 0, 0);
    enqueue_request(REQ_DEL_FRONT, 0, 0);
    enqueue_request(REQ_DEL_BACK, 0, 0);
    enqueue_request(REQ_DEL_VALUE, 0, 0);
    enqueue_request(REQ_INS_POS, 7, 0);
    enqueue_request(REQ_INS_POS, 7, 2);
    enqueue_request(REQ_INS_POS, 5, 1);
    enqueue_request(REQ_DEL_FRONT, 0, 0);
    enqueue_request(REQ_INS_POS, 32'sh7fff_ffff, 1);
    enqueue_request(REQ_DEL_BACK, 0, 0);
    enqueue_request(REQ_INS_FRONT, 32'sh8000_0000, 0);
    enqueue_request(REQ_INS_BACK, 32'sh7fff_ffff, 0);
    enqueue_request(REQ_INS_POS, 9, 7'd127);
    enqueue_request(REQ_INS_POS, -1, 3);
    enqueue_request(REQ_INS_POS, 0, 2);
    enqueue_request(REQ_INS_POS, 1, 1);
    enqueue_request(REQ_READ_ALL, 0, 0);
    enqueue_request(REQ_DEL_VALUE, 32'sh1234_5678, 0);
    enqueue_request(REQ_INS_BACK, 1, 0);
    enqueue_request(REQ_DEL_VALUE, 1, 0);
    enqueue_request(REQ_DEL_VALUE, -1, 0);
    enqueue_request(REQ_UNUSED, 32'sh5a5a_a5a5, 7'h55);
    enqueue_request(REQ_DEL_FRONT, 0, 0);
    enqueue_request(REQ_DEL_BACK, 0, 0);
    enqueue_request(REQ_READ_ALL, 0, 0);
    settle();

    // fill to capacity behind a long receiver hold-off, then empty it again
    hold_req = 300;
    for (k = 0; k < CAP; k++)
      enqueue_request(REQ_INS_BACK, $urandom, 0);
    enqueue_request(REQ_INS_FRONT, 3, 0);
    enqueue_request(REQ_INS_POS, 3, POS_W'(CAP + 1));
    enqueue_request(REQ_INS_POS, 3, POS_W'(CAP + 2));
    enqueue_request(REQ_INS_POS, 3, 0);
    enqueue_request(REQ_READ_ALL, 0, 0);
    enqueue_request(REQ_DEL_VALUE, 32'sh7fff_ffff, 0);
    enqueue_request(REQ_INS_POS, $urandom, POS_W'(CAP / 2));
    for (k = 0; k <= CAP; k++)
      enqueue_request(REQ_DEL_BACK, 0, 0);
    settle();

    for (p = 0; p < 4; p++) begin
      idle_pct  = idle_plan[p];
      stall_pct = stall_plan[p];
      for (b = 0; b < 5; b++)
        for (k = 0; k < 13; k++)
          request_backlog.push_back(random_request(b % 2 == 0));
      settle();
    end

    if (mismatches == 0) $display("tb_ordered_list_engine passed");
    else $display("tb_ordered_list_engine failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ole_pkg.sv
hdl/ole_ifs.sv
hdl/ole_datapath.sv
hdl/ole_ctrl.sv
hdl/ordered_list_engine.sv
tb/sv/tb_ordered_list_engine.sv
